/* rtl/core/amu_pkg.sv */
// shared constants and types for the smoothed arg-max classifier
`timescale 1ns / 1ps
`default_nettype none

package amu_pkg;

   // fixed widths of the word fields
   localparam int FIELD_W     = 16;
   localparam int PROB_FIELDS = 8;
   localparam int ALPHA_W     = 16;
   localparam int MARGIN_W    = 16;
   localparam int UNK_W       = 3;
   localparam int CLASS_W     = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   // one in q0.16, the complement base for the weight of the old value
   localparam logic [ALPHA_W:0] ONE_Q16 = 17'h10000;

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SMOOTHING_ALPHA = 2'd0,
      CSR_UNKNOWN_MARGIN  = 2'd1,
      CSR_UNKNOWN_INDEX   = 2'd2,
      CSR_UNUSED          = 2'd3
   } csr_index_type;

   // reset values of the registers
   localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 16'd19661;
   localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd13107;
   localparam logic [UNK_W-1:0]    UNK_RESET    = 3'd1;

endpackage

`default_nettype wire

/* rtl/core/amu_ifc.sv */
// channel interfaces: probability words in, class words out, register writes
`timescale 1ns / 1ps
`default_nettype none

interface amu_req_if import amu_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] prob_0;
   logic [FIELD_W-1:0] prob_1;
   logic [FIELD_W-1:0] prob_2;
   logic [FIELD_W-1:0] prob_3;
   logic [FIELD_W-1:0] prob_4;
   logic [FIELD_W-1:0] prob_5;
   logic [FIELD_W-1:0] prob_6;
   logic [FIELD_W-1:0] prob_7;

   modport source (output valid, prob_0, prob_1, prob_2, prob_3, prob_4, prob_5,
                   prob_6, prob_7, input ready);
   modport sink   (input valid, prob_0, prob_1, prob_2, prob_3, prob_4, prob_5,
                   prob_6, prob_7, output ready);
endinterface

interface amu_rsp_if import amu_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CLASS_W-1:0] chosen_class;

   modport source (output valid, chosen_class, input ready);
   modport sink   (input valid, chosen_class, output ready);
endinterface

interface amu_csr_if import amu_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/amu_ema_lane.sv */
// one class lane: smoothed value register and its multiply-add update
`timescale 1ns / 1ps
`default_nettype none

module amu_ema_lane import amu_pkg::*; #(
   parameter int PROB_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 update,
   input  wire logic [ALPHA_W-1:0]   alpha,
   input  wire logic [PROB_BITS-1:0] raw,
   output      logic [PROB_BITS-1:0] smoothed
);

   localparam int ACC_W = PROB_BITS + ALPHA_W + 1;

   logic [PROB_BITS-1:0] smoothed_ff;
   logic [PROB_BITS-1:0] smoothed_in;
   logic [ALPHA_W:0]     beta;
   logic [ACC_W-1:0]     acc;

   // weight of the old value, 1..65536
   assign beta = ONE_Q16 - {1'b0, alpha};
   assign acc  = ACC_W'(alpha) * ACC_W'(raw) + ACC_W'(beta) * ACC_W'(smoothed_ff);
   assign smoothed_in = acc[ALPHA_W +: PROB_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         smoothed_ff <= '0;
      end else if (update) begin
         smoothed_ff <= smoothed_in;
      end
   end

   assign smoothed = smoothed_ff;

endmodule

`default_nettype wire

/* rtl/core/amu_rank.sv */
// registered arg-max search: overall winner and best class other than unknown
`timescale 1ns / 1ps
`default_nettype none

module amu_rank import amu_pkg::*; #(
   parameter int CLASS_COUNT = 8,
   parameter int PROB_BITS   = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  load,
   input  wire logic [CLASS_COUNT-1:0][PROB_BITS-1:0] vals,
   input  wire logic [UNK_W-1:0]                      unk_index,
   output      logic [$clog2(CLASS_COUNT)-1:0]        top_idx,
   output      logic [$clog2(CLASS_COUNT)-1:0]        alt_idx,
   output      logic [PROB_BITS-1:0]                  top_val,
   output      logic [PROB_BITS-1:0]                  alt_val
);

   localparam int IDX_W  = $clog2(CLASS_COUNT);
   localparam int LEAVES = 1 << IDX_W;
   localparam int CMP_W  = (IDX_W > UNK_W) ? IDX_W : UNK_W;

   // heap-ordered trees, left child is always the lower index
   logic                 t_ok  [1:2*LEAVES-1];
   logic [IDX_W-1:0]     t_idx [1:2*LEAVES-1];
   logic [PROB_BITS-1:0] t_val [1:2*LEAVES-1];
   logic                 a_ok  [1:2*LEAVES-1];
   logic [IDX_W-1:0]     a_idx [1:2*LEAVES-1];
   logic [PROB_BITS-1:0] a_val [1:2*LEAVES-1];

   logic [IDX_W-1:0]     top_idx_ff, alt_idx_ff;
   logic [PROB_BITS-1:0] top_val_ff, alt_val_ff;

   always_comb begin
      for (int i = 0; i < LEAVES; i++) begin
         t_ok[LEAVES+i]  = (i < CLASS_COUNT);
         t_idx[LEAVES+i] = IDX_W'(i);
         t_val[LEAVES+i] = (i < CLASS_COUNT) ? vals[i % CLASS_COUNT] : '0;
         a_ok[LEAVES+i]  = (i < CLASS_COUNT) && (CMP_W'(i) != CMP_W'(unk_index));
         a_idx[LEAVES+i] = IDX_W'(i);
         a_val[LEAVES+i] = t_val[LEAVES+i];
      end
      // ties keep the left, lower index
      for (int n = LEAVES - 1; n >= 1; n--) begin
         if (!t_ok[2*n] || (t_ok[2*n+1] && (t_val[2*n+1] > t_val[2*n]))) begin
            t_ok[n]  = t_ok[2*n+1];
            t_idx[n] = t_idx[2*n+1];
            t_val[n] = t_val[2*n+1];
         end else begin
            t_ok[n]  = t_ok[2*n];
            t_idx[n] = t_idx[2*n];
            t_val[n] = t_val[2*n];
         end
         if (!a_ok[2*n] || (a_ok[2*n+1] && (a_val[2*n+1] > a_val[2*n]))) begin
            a_ok[n]  = a_ok[2*n+1];
            a_idx[n] = a_idx[2*n+1];
            a_val[n] = a_val[2*n+1];
         end else begin
            a_ok[n]  = a_ok[2*n];
            a_idx[n] = a_idx[2*n];
            a_val[n] = a_val[2*n];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         top_idx_ff <= t_idx[1];
         top_val_ff <= t_val[1];
         alt_idx_ff <= a_idx[1];
         alt_val_ff <= a_val[1];
      end
   end

   assign top_idx = top_idx_ff;
   assign top_val = top_val_ff;
   assign alt_idx = alt_idx_ff;
   assign alt_val = alt_val_ff;

endmodule

`default_nettype wire

/* rtl/core/ema_argmax_unknown_margin_core.sv */
// top level of the smoothed arg-max classifier with unknown-class margin
//
// usage
//   req_bus carries one word per inference window: eight q0.16 class
//   probabilities. rsp_bus returns one word per window: the chosen class.
//   csr_bus writes the registers: 0 smoothing alpha, 1 unknown margin,
//   2 unknown class index. it is always ready; write only while idle.
// timing
//   one word per cycle sustained while rsp_bus is ready. a word passes these
//   registered stages in order on its way to rsp_bus.valid: input register
//   (loaded at acceptance), smoothed store (the per-class multiply-add
//   feedback loop, one update a cycle), rank register, output register.
//   the smoothed-value loop is what fixes the one-cycle rate
// stalls
//   each stage moves on when the next one is empty or moving, so a held
//   result still lets up to three more words in before req_bus.ready drops
// reset
//   clears the stage valid flags, the smoothed store and the registers to
//   their defaults at once; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module ema_argmax_unknown_margin_core import amu_pkg::*; #(
   parameter int CLASS_COUNT = 8,
   parameter int PROB_BITS   = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   amu_req_if.sink    req_bus,
   amu_rsp_if.source  rsp_bus,
   amu_csr_if.sink    csr_bus
);

   localparam int IDX_W = $clog2(CLASS_COUNT);
   localparam int CMP_W = (IDX_W > UNK_W) ? IDX_W : UNK_W;

   // registers
   logic [ALPHA_W-1:0]  alpha_ff;
   logic [MARGIN_W-1:0] margin_ff;
   logic [UNK_W-1:0]    unk_ff;

   // stage valid flags
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic s4_valid_ff, s4_valid_in;

   // handshake between stages
   logic s1_ready, s2_ready, s3_ready, s4_ready;
   logic load1, adv1, adv2, adv3, take4;

   // payload
   logic [FIELD_W-1:0]                  fields [PROB_FIELDS];
   logic [CLASS_COUNT-1:0][PROB_BITS-1:0] s1_raw_in;
   logic [CLASS_COUNT-1:0][PROB_BITS-1:0] s1_raw_ff;
   logic [CLASS_COUNT-1:0][PROB_BITS-1:0] smoothed;
   logic [IDX_W-1:0]     s3_top_idx, s3_alt_idx;
   logic [PROB_BITS-1:0] s3_top_val, s3_alt_val;
   logic [PROB_BITS-1:0] margin_scaled;
   logic [PROB_BITS-1:0] lead;
   logic                 is_unknown;
   logic [IDX_W-1:0]     s4_idx_ff, s4_idx_in;

   // ---------------- register port ----------------
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= ALPHA_RESET;
         margin_ff <= MARGIN_RESET;
         unk_ff    <= UNK_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_SMOOTHING_ALPHA: alpha_ff  <= csr_bus.data[ALPHA_W-1:0];
            CSR_UNKNOWN_MARGIN:  margin_ff <= csr_bus.data[MARGIN_W-1:0];
            CSR_UNKNOWN_INDEX:   unk_ff    <= csr_bus.data[UNK_W-1:0];
            default: ;
         endcase
      end
   end

   // margin moved to the probability scale, truncating when narrower
   if (PROB_BITS >= MARGIN_W) begin : g_margin_wide
      assign margin_scaled = PROB_BITS'(margin_ff) << (PROB_BITS - MARGIN_W);
   end else begin : g_margin_narrow
      assign margin_scaled = PROB_BITS'(margin_ff >> (MARGIN_W - PROB_BITS));
   end

   // ---------------- pipeline control ----------------
   assign take4    = rsp_bus.valid && rsp_bus.ready;
   assign s4_ready = !s4_valid_ff || rsp_bus.ready;
   assign adv3     = s3_valid_ff && s4_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign adv2     = s2_valid_ff && s3_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign adv1     = s1_valid_ff && s2_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign load1    = req_bus.valid && s1_ready;

   assign req_bus.ready = s1_ready;

   assign s1_valid_in = load1 ? 1'b1 : (adv1 ? 1'b0 : s1_valid_ff);
   assign s2_valid_in = adv1  ? 1'b1 : (adv2 ? 1'b0 : s2_valid_ff);
   assign s3_valid_in = adv2  ? 1'b1 : (adv3 ? 1'b0 : s3_valid_ff);
   assign s4_valid_in = adv3  ? 1'b1 : (take4 ? 1'b0 : s4_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   // ---------------- stage 1: input register ----------------
   assign fields[0] = req_bus.prob_0;
   assign fields[1] = req_bus.prob_1;
   assign fields[2] = req_bus.prob_2;
   assign fields[3] = req_bus.prob_3;
   assign fields[4] = req_bus.prob_4;
   assign fields[5] = req_bus.prob_5;
   assign fields[6] = req_bus.prob_6;
   assign fields[7] = req_bus.prob_7;

   // classes beyond the word's fields see a raw value of zero
   for (genvar gi = 0; gi < CLASS_COUNT; gi++) begin : g_raw
      if (gi < PROB_FIELDS) begin : g_field
         assign s1_raw_in[gi] = PROB_BITS'(fields[gi]);
      end else begin : g_zero
         assign s1_raw_in[gi] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         s1_raw_ff <= s1_raw_in;
      end
   end

   // ---------------- stage 2: smoothed store ----------------
   // the store itself is the stage register; it only moves on when the
   // rank stage has taken the previous values
   for (genvar gl = 0; gl < CLASS_COUNT; gl++) begin : g_lane
      amu_ema_lane #(
         .PROB_BITS (PROB_BITS)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .update   (adv1),
         .alpha    (alpha_ff),
         .raw      (s1_raw_ff[gl]),
         .smoothed (smoothed[gl])
      );
   end

   // ---------------- stage 3: rank ----------------
   amu_rank #(
      .CLASS_COUNT (CLASS_COUNT),
      .PROB_BITS   (PROB_BITS)
   ) u_rank (
      .clock     (clock),
      .load      (adv2),
      .vals      (smoothed),
      .unk_index (unk_ff),
      .top_idx   (s3_top_idx),
      .alt_idx   (s3_alt_idx),
      .top_val   (s3_top_val),
      .alt_val   (s3_alt_val)
   );

   // ---------------- stage 4: decision and output register ----------------
   // unknown yields to the best other class when its lead is short
   assign is_unknown = (CMP_W'(s3_top_idx) == CMP_W'(unk_ff));
   assign lead       = s3_top_val - s3_alt_val;
   assign s4_idx_in  = (is_unknown && (lead < margin_scaled)) ? s3_alt_idx : s3_top_idx;

   always_ff @(posedge clock) begin
      if (adv3) begin
         s4_idx_ff <= s4_idx_in;
      end
   end

   assign rsp_bus.valid        = s4_valid_ff;
   assign rsp_bus.chosen_class = CLASS_W'(s4_idx_ff);

   // ---------------- checks ----------------
   // an accepted word always lands in the input stage
   a_accept_lands : assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> s1_valid_ff)
      else $error("accepted word lost at input stage");

   // the overall winner never trails the best other class
   a_rank_order : assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (s3_top_val >= s3_alt_val))
      else $error("rank stage winner below alternative");

   // the reported class is always a real class
   a_class_range : assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> (int'(s4_idx_ff) < CLASS_COUNT))
      else $error("chosen class out of range");

endmodule

`default_nettype wire
